// File: hw/rtl/qte_pkg.sv
// Shared types and constants for the quaternion to Euler angle converter.
package qte_pkg;

  localparam logic [1:0] KIND_ROLL  = 2'd0;
  localparam logic [1:0] KIND_PITCH = 2'd1;
  localparam logic [1:0] KIND_YAW   = 2'd2;
  localparam logic [1:0] KIND_NONE  = 2'd3;

  localparam int PW     = 34;  // width of atan2 arguments (Q.28)
  localparam int XW     = 37;  // CORDIC x/y datapath width
  localparam int ZW     = 34;  // CORDIC angle width (Q.30)
  localparam int SQ_N   = 29;  // result bits of the square root
  localparam int RAD_W  = 58;  // radicand width, padded to an even bit count
  localparam int ATAN_N = 24;
  localparam int ANGLE_LIMIT = 25736;

  localparam logic signed [PW-1:0] ONE_Q28 = PW'(64'sd268435456);

  localparam logic [31:0] ATAN_Q30 [ATAN_N] = '{
    32'd843314857, 32'd497837829, 32'd263043836, 32'd133525158, 32'd67021686,
    32'd33543515, 32'd16775850, 32'd8388437, 32'd4194282, 32'd2097149,
    32'd1048575, 32'd524287, 32'd262143, 32'd131071, 32'd65535, 32'd32767,
    32'd16383, 32'd8191, 32'd4095, 32'd2047, 32'd1023, 32'd511, 32'd255, 32'd127
  };

  typedef struct packed {
    logic [1:0]              kind;
    logic                    flag;
    logic signed [PW-1:0]    px;
    logic signed [PW-1:0]    py;
  } qte_side_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       flag;
    logic       zero;
  } qte_tag_t;

endpackage

// File: hw/rtl/qte_front.sv
// Front end: quaternion products, atan2 arguments, pitch clamp and radicand.
module qte_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic [1:0]                 kind,
  input  logic signed [15:0]         quat_w,
  input  logic signed [15:0]         quat_x,
  input  logic signed [15:0]         quat_y,
  input  logic signed [15:0]         quat_z,
  output logic                       out_valid,
  output qte_pkg::qte_side_t         out_side,
  output logic [qte_pkg::RAD_W-1:0]  out_rad
);
  import qte_pkg::*;

  logic                v1, v2, v3, v4, v5;
  logic [1:0]          k1, k2;
  logic signed [15:0]  w1, x1, y1, z1;
  logic signed [15:0]  ma, mb, mc, md, me, mf, mg, mh;
  logic signed [31:0]  pa, pb, pc, pd;
  qte_side_t           side3, side4, side5;
  qte_side_t           side3_next;
  logic [28:0]         smag3, smag3_next;
  logic [57:0]         sq4;
  logic [RAD_W-1:0]    rad5;
  logic signed [PW-1:0] sum_ab, dif_ab, sum_cd, s_raw;

  // Operand selection per angle kind
  always_comb begin
    ma = '0; mb = '0; mc = '0; md = '0;
    me = '0; mf = '0; mg = '0; mh = '0;
    case (k1)
      KIND_ROLL: begin
        ma = w1; mb = x1; mc = y1; md = z1;
        me = x1; mf = x1; mg = y1; mh = y1;
      end
      KIND_PITCH: begin
        ma = w1; mb = y1; mc = z1; md = x1;
      end
      KIND_YAW: begin
        ma = w1; mb = z1; mc = x1; md = y1;
        me = y1; mf = y1; mg = z1; mh = z1;
      end
      default: ;
    endcase
  end

  always_comb begin
    sum_ab = PW'(pa) + PW'(pb);
    dif_ab = PW'(pa) - PW'(pb);
    sum_cd = PW'(pc) + PW'(pd);
    s_raw  = dif_ab <<< 1;
    side3_next.kind = k2;
    side3_next.flag = 1'b0;
    side3_next.px   = ONE_Q28 - (sum_cd <<< 1);
    side3_next.py   = sum_ab <<< 1;
    smag3_next      = '0;
    if (k2 == KIND_PITCH) begin
      side3_next.px = '0;
      side3_next.py = s_raw;
      if (s_raw > ONE_Q28) begin
        side3_next.py   = ONE_Q28;
        side3_next.flag = 1'b1;
      end else if (s_raw < -ONE_Q28) begin
        side3_next.py   = -ONE_Q28;
        side3_next.flag = 1'b1;
      end
      smag3_next = side3_next.py[PW-1] ? 29'(-side3_next.py) : 29'(side3_next.py);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0; v5 <= 1'b0;
    end else begin
      v1 <= in_valid; v2 <= v1; v3 <= v2; v4 <= v3; v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    k1 <= kind; w1 <= quat_w; x1 <= quat_x; y1 <= quat_y; z1 <= quat_z;
    k2 <= k1;
    pa <= ma * mb;
    pb <= mc * md;
    pc <= me * mf;
    pd <= mg * mh;
    side3 <= side3_next;
    smag3 <= smag3_next;
    side4 <= side3;
    sq4   <= smag3 * smag3;
    side5 <= side4;
    rad5  <= RAD_W'(58'd1 << 56) - sq4;
  end

  assign out_valid = v5;
  assign out_side  = side5;
  assign out_rad   = rad5;

endmodule

// File: hw/rtl/qte_sqrt.sv
// Pipelined floor square root, one result bit per stage, with sideband carry.
module qte_sqrt (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  qte_pkg::qte_side_t         in_side,
  input  logic [qte_pkg::RAD_W-1:0]  in_rad,
  output logic                       out_valid,
  output qte_pkg::qte_side_t         out_side,
  output logic [qte_pkg::SQ_N-1:0]   out_root
);
  import qte_pkg::*;

  logic              vld  [SQ_N+1];
  qte_side_t         side [SQ_N+1];
  logic [RAD_W-1:0]  rad  [SQ_N+1];
  logic [31:0]       rem  [SQ_N+1];
  logic [SQ_N-1:0]   root [SQ_N+1];

  assign vld[0]  = in_valid;
  assign side[0] = in_side;
  assign rad[0]  = in_rad;
  assign rem[0]  = '0;
  assign root[0] = '0;

  for (genvar i = 0; i < SQ_N; i++) begin : g_step
    logic [31:0] rem_t, trial;
    always_comb begin
      rem_t = {rem[i][29:0], rad[i][RAD_W-1 -: 2]};
      trial = {1'b0, root[i], 2'b01};
    end
    always_ff @(posedge clk) begin
      if (rst) vld[i+1] <= 1'b0;
      else     vld[i+1] <= vld[i];
    end
    always_ff @(posedge clk) begin
      side[i+1] <= side[i];
      rad[i+1]  <= rad[i] << 2;
      if (rem_t >= trial) begin
        rem[i+1]  <= rem_t - trial;
        root[i+1] <= {root[i][SQ_N-2:0], 1'b1};
      end else begin
        rem[i+1]  <= rem_t;
        root[i+1] <= {root[i][SQ_N-2:0], 1'b0};
      end
    end
  end

  assign out_valid = vld[SQ_N];
  assign out_side  = side[SQ_N];
  assign out_root  = root[SQ_N];

endmodule

// File: hw/rtl/qte_cordic.sv
// Unrolled vectoring CORDIC atan2 with final rounding and saturation.
module qte_cordic #(
  parameter int STEPS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  qte_pkg::qte_tag_t           in_tag,
  input  logic signed [qte_pkg::PW-1:0] in_x,
  input  logic signed [qte_pkg::PW-1:0] in_y,
  output logic                        out_valid,
  output logic signed [15:0]          out_angle,
  output logic                        out_flag
);
  import qte_pkg::*;

  logic                 vld [STEPS+1];
  qte_tag_t             tag [STEPS+1];
  logic signed [XW-1:0] xr  [STEPS+1];
  logic signed [XW-1:0] yr  [STEPS+1];
  logic signed [ZW-1:0] zr  [STEPS+1];

  logic signed [XW-1:0] xe, ye;
  logic signed [ZW-1:0] zf, zsum;
  logic signed [ZW-1:0] qa;
  logic signed [15:0]   angle_next;
  logic                 vout;
  logic signed [15:0]   angle_q;
  logic                 flag_q;

  assign xe = XW'(in_x);
  assign ye = XW'(in_y);

  // Quadrant pre-rotation for negative x
  always_ff @(posedge clk) begin
    if (rst) vld[0] <= 1'b0;
    else     vld[0] <= in_valid;
  end
  always_ff @(posedge clk) begin
    tag[0].kind <= in_tag.kind;
    tag[0].flag <= in_tag.flag;
    tag[0].zero <= in_tag.zero || ((in_x == '0) && (in_y == '0));
    if (xe < 0) begin
      if (ye >= 0) begin
        xr[0] <= ye; yr[0] <= -xe; zr[0] <= ZW'({ATAN_Q30[0], 1'b0});
      end else begin
        xr[0] <= -ye; yr[0] <= xe; zr[0] <= -ZW'({ATAN_Q30[0], 1'b0});
      end
    end else begin
      xr[0] <= xe; yr[0] <= ye; zr[0] <= '0;
    end
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    logic signed [ZW-1:0] a_i;
    assign a_i = ZW'(ATAN_Q30[i]);
    always_ff @(posedge clk) begin
      if (rst) vld[i+1] <= 1'b0;
      else     vld[i+1] <= vld[i];
    end
    always_ff @(posedge clk) begin
      tag[i+1] <= tag[i];
      if (yr[i] >= 0) begin
        xr[i+1] <= xr[i] + (yr[i] >>> i);
        yr[i+1] <= yr[i] - (xr[i] >>> i);
        zr[i+1] <= zr[i] + a_i;
      end else begin
        xr[i+1] <= xr[i] - (yr[i] >>> i);
        yr[i+1] <= yr[i] + (xr[i] >>> i);
        zr[i+1] <= zr[i] - a_i;
      end
    end
  end

  // Round to Q3.13, negate for roll, saturate, force zero when tagged
  always_comb begin
    zf   = (tag[STEPS].kind == KIND_ROLL) ? -zr[STEPS] : zr[STEPS];
    zsum = zf + ZW'(65536);
    qa   = zsum >>> 17;
    if (tag[STEPS].zero)                    angle_next = '0;
    else if (qa > ZW'(ANGLE_LIMIT))         angle_next = 16'(ANGLE_LIMIT);
    else if (qa < -ZW'(ANGLE_LIMIT))        angle_next = -16'(ANGLE_LIMIT);
    else                                    angle_next = qa[15:0];
  end

  always_ff @(posedge clk) begin
    if (rst) vout <= 1'b0;
    else     vout <= vld[STEPS];
  end
  always_ff @(posedge clk) begin
    angle_q <= angle_next;
    flag_q  <= tag[STEPS].flag;
  end

  assign out_valid = vout;
  assign out_angle = angle_q;
  assign out_flag  = flag_q;

endmodule

// File: hw/rtl/quaternion_to_euler_angle.sv
// Top level: quaternion to roll, pitch or yaw angle converter.
//
// Usage: drive kind and quat_w/x/y/z and pulse start; a transfer happens on
// any rising edge with start high and busy low. busy is always low, so a new
// quaternion can be presented on every cycle.
// Each transfer produces exactly one result: done is high for one cycle with
// angle (Q3.13 radians) and domain_clamped valid in that same cycle.
// The pipeline holds five front-end stages (input register, multiply, sum
// and clamp, square, radicand), one stage per bit of the 29-bit square
// root, the pre-rotation stage and one stage per CORDIC iteration, and the
// output register.
// Throughput is one item per cycle.
// The receiver cannot hold results off; results leave in transfer order.
// Synchronous reset clears all valid bits, dropping items in flight.
module quaternion_to_euler_angle #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         kind,
  input  logic signed [15:0] quat_w,
  input  logic signed [15:0] quat_x,
  input  logic signed [15:0] quat_y,
  input  logic signed [15:0] quat_z,
  output logic               done,
  output logic signed [15:0] angle,
  output logic               domain_clamped
);
  import qte_pkg::*;

  logic              f_valid, s_valid;
  qte_side_t         f_side, s_side;
  logic [RAD_W-1:0]  f_rad;
  logic [SQ_N-1:0]   s_root;
  qte_tag_t          c_tag;
  logic signed [PW-1:0] c_x;

  assign busy = 1'b0;

  qte_front u_front (
    .clk(clk), .rst(rst), .in_valid(start && !busy), .kind(kind),
    .quat_w(quat_w), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z),
    .out_valid(f_valid), .out_side(f_side), .out_rad(f_rad)
  );

  qte_sqrt u_sqrt (
    .clk(clk), .rst(rst), .in_valid(f_valid), .in_side(f_side), .in_rad(f_rad),
    .out_valid(s_valid), .out_side(s_side), .out_root(s_root)
  );

  always_comb begin
    c_tag.kind = s_side.kind;
    c_tag.flag = s_side.flag;
    // Force a zero angle for the unused selector
    c_tag.zero = (s_side.kind == KIND_NONE);
    c_x = (s_side.kind == KIND_PITCH) ? PW'(s_root) : s_side.px;
  end

  qte_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk(clk), .rst(rst), .in_valid(s_valid), .in_tag(c_tag),
    .in_x(c_x), .in_y(s_side.py),
    .out_valid(done), .out_angle(angle), .out_flag(domain_clamped)
  );

endmodule
